FILE: src/midi_track_event_parser_macros.svh
// ----------------------------------------------------------------------------
// midi_track_event_parser_macros.svh
// Assertion macros shared by the parser RTL. They sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define MTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define MTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, codes and constants of the MIDI track event parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

    // Default tick accumulator width
    localparam int DEF_TICK_WIDTH = 32;

    // Parser phases
    typedef enum logic [3:0] {
        PH_DELTA    = 4'd0,
        PH_STATUS   = 4'd1,
        PH_SYSLEN   = 4'd2,
        PH_METATYPE = 4'd3,
        PH_METALEN  = 4'd4,
        PH_SKIP     = 4'd5,
        PH_TEMPO    = 4'd6,
        PH_DATA1    = 4'd7,
        PH_DATA2    = 4'd8
    } phase_t;

    // Event kinds
    typedef enum logic [4:0] {
        EV_NOTEOFF    = 5'd0,
        EV_NOTEON     = 5'd1,
        EV_KEYPRESS   = 5'd2,
        EV_VOLUME     = 5'd3,
        EV_PAN        = 5'd4,
        EV_EXPRESSION = 5'd5,
        EV_SUSTAIN    = 5'd6,
        EV_SOUNDSOFF  = 5'd7,
        EV_RESETCTL   = 5'd8,
        EV_NOTESOFF   = 5'd9,
        EV_MONO       = 5'd10,
        EV_POLY       = 5'd11,
        EV_BANK       = 5'd12,
        EV_PITCHSENS  = 5'd13,
        EV_PROGRAM    = 5'd14,
        EV_PITCHWHEEL = 5'd15,
        EV_TEMPO      = 5'd16,
        EV_EOT        = 5'd17
    } kind_t;

    // Status classes (status byte bits 6:4)
    localparam logic [2:0] ST_NOTEOFF    = 3'd0;
    localparam logic [2:0] ST_NOTEON     = 3'd1;
    localparam logic [2:0] ST_KEYPRESS   = 3'd2;
    localparam logic [2:0] ST_CONTROL    = 3'd3;
    localparam logic [2:0] ST_PROGRAM    = 3'd4;
    localparam logic [2:0] ST_CHANPRESS  = 3'd5;
    localparam logic [2:0] ST_PITCHWHEEL = 3'd6;
    localparam logic [2:0] ST_SYSTEM     = 3'd7;

    // Special bytes
    localparam logic [7:0] BYTE_SYSEX      = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] BYTE_META       = 8'hFF;
    localparam logic [7:0] META_EOT        = 8'h2F;
    localparam logic [7:0] META_TEMPO      = 8'h51;

    // Controller numbers
    localparam logic [6:0] CC_BANK       = 7'd0;
    localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
    localparam logic [6:0] CC_VOLUME     = 7'd7;
    localparam logic [6:0] CC_PAN        = 7'd10;
    localparam logic [6:0] CC_EXPRESSION = 7'd11;
    localparam logic [6:0] CC_SUSTAIN    = 7'd64;
    localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
    localparam logic [6:0] CC_RPN_LSB    = 7'd100;
    localparam logic [6:0] CC_RPN_MSB    = 7'd101;
    localparam logic [6:0] CC_SOUNDSOFF  = 7'd120;
    localparam logic [6:0] CC_RESETCTL   = 7'd121;
    localparam logic [6:0] CC_NOTESOFF   = 7'd123;
    localparam logic [6:0] CC_MONO       = 7'd126;
    localparam logic [6:0] CC_POLY       = 7'd127;

    // Parameter numbers seen by data entry
    localparam logic [13:0] PARAM_PITCHSENS = 14'h0000;
    localparam logic [13:0] PARAM_NULL      = 14'h3FFF;
    localparam logic [6:0]  NULL_PITCHSENS  = 7'd2;
    localparam logic [2:0]  TEMPO_LEN       = 3'd3;

    // Table write request
    typedef struct packed {
        logic       en;
        logic       lsb;
        logic [3:0] chan;
        logic [6:0] value;
    } param_wr_t;

    // Event waiting for its table lookup
    typedef struct packed {
        kind_t       kind;
        logic [31:0] tick;
        logic [3:0]  chan;
        logic [6:0]  key;
        logic [6:0]  vel;
        logic [23:0] tempo;
        logic        dentry;
    } pending_t;

endpackage

`default_nettype wire

FILE: src/mtp_param_store.sv
// ----------------------------------------------------------------------------
// mtp_param_store
// Per-channel RPN/NRPN parameter number store: two 16x7 memories with one
// write and one registered read per cycle, and valid bits for clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_param_store
    import mtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire param_wr_t   wr,
    input  wire logic        rd_en,
    input  wire logic [3:0]  rd_chan,
    output logic      [13:0] rd_word
);

    logic [6:0]  msb_mem [16];
    logic [6:0]  lsb_mem [16];
    logic [15:0] msb_valid_reg;
    logic [15:0] lsb_valid_reg;
    logic [15:0] msb_valid_next;
    logic [15:0] lsb_valid_next;
    logic [13:0] rd_word_reg;

    // Set valid on write, drop all on clear
    always_comb
    begin
        msb_valid_next = msb_valid_reg;
        lsb_valid_next = lsb_valid_reg;
        if (clear)
        begin
            msb_valid_next = '0;
            lsb_valid_next = '0;
        end
        else if (wr.en && !wr.lsb)
        begin
            msb_valid_next[wr.chan] = 1'b1;
        end
        else if (wr.en && wr.lsb)
        begin
            lsb_valid_next[wr.chan] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msb_valid_reg <= '0;
            lsb_valid_reg <= '0;
        end
        else
        begin
            msb_valid_reg <= msb_valid_next;
            lsb_valid_reg <= lsb_valid_next;
        end
    end

    // Write the selected half
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.lsb)
        begin
            msb_mem[wr.chan] <= wr.value;
        end
        if (wr.en && wr.lsb)
        begin
            lsb_mem[wr.chan] <= wr.value;
        end
    end

    // Registered read; an entry never written reads as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= {msb_valid_reg[rd_chan] ? msb_mem[rd_chan] : 7'd0,
                            lsb_valid_reg[rd_chan] ? lsb_mem[rd_chan] : 7'd0};
        end
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

FILE: src/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses standard MIDI file track data, one byte per request, into events.
// ----------------------------------------------------------------------------
// The parser takes one track byte per clock cycle unless the master side
// stalls while the pending event and the output register are both full.
// It gives at most one event per byte. The parse and the read of the
// per-channel parameter memory fill the pending event, which then moves to
// the output register; the two let the input keep flowing while one result
// waits. Delta times accumulate into a TICK_WIDTH tick counter whose low 32
// bits go out with each event. A request with tuser set restarts the track.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_track_event_parser_macros.svh"

module midi_track_event_parser
    import mtp_pkg::*;
#(
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] start_of_track
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [4:0] event_kind, [36:5] tick_time, [40:37] channel,
    // [47:41] key_or_value, [54:48] velocity, [78:55] tempo_us, [79] zero
    output logic      [79:0] m_tdata
);

    localparam int TICK_EXT = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

    // Parser state
    phase_t                  phase_reg,  phase_next;
    logic [TICK_WIDTH-1:0]   tick_reg,   tick_next;
    logic [31:0]             delta_reg,  delta_next;
    logic [2:0]              status_reg, status_next;
    logic [3:0]              chan_reg,   chan_next;
    logic                    nrpn_reg,   nrpn_next;
    logic [7:0]              meta_reg,   meta_next;
    logic [31:0]             skip_reg,   skip_next;
    logic [6:0]              first_reg,  first_next;
    logic [15:0]             tempo_reg,  tempo_next;
    logic                    ended_reg,  ended_next;

    // Pipeline registers
    logic                    p_valid_reg;
    pending_t                p_reg;
    logic                    out_valid_reg;
    pending_t                out_reg;

    logic                    s_accept;
    logic                    p_move;
    logic [7:0]              c;
    logic [31:0]             delta_sum;
    logic [31:0]             skip_sum;
    logic [31:0]             skip_dec;
    logic [TICK_EXT-1:0]     tick_ext;
    pending_t                ev;
    logic                    ev_valid;
    param_wr_t               wr;
    logic                    rd_en;
    logic [13:0]             rd_word;
    pending_t                fin;
    logic                    keep;

    assign c        = s_tdata;
    assign p_move   = !out_valid_reg || m_tready;
    assign s_tready = !p_valid_reg || p_move;
    assign s_accept = s_tvalid && s_tready;

    assign delta_sum = delta_reg + {25'd0, c[6:0]};
    assign skip_sum  = skip_reg + {25'd0, c[6:0]};
    assign skip_dec  = skip_reg - 32'd1;
    assign tick_ext  = TICK_EXT'(tick_reg);

    // Parse one byte: next state, event and table access
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        delta_next  = delta_reg;
        status_next = status_reg;
        chan_next   = chan_reg;
        nrpn_next   = nrpn_reg;
        meta_next   = meta_reg;
        skip_next   = skip_reg;
        first_next  = first_reg;
        tempo_next  = tempo_reg;
        ended_next  = ended_reg;
        ev_valid    = 1'b0;
        ev.kind     = EV_NOTEOFF;
        ev.tick     = tick_ext[31:0];
        ev.chan     = chan_reg;
        ev.key      = '0;
        ev.vel      = '0;
        ev.tempo    = '0;
        ev.dentry   = 1'b0;
        wr.en       = 1'b0;
        wr.lsb      = 1'b0;
        wr.chan     = chan_reg;
        wr.value    = c[6:0];
        rd_en       = 1'b0;

        if (s_accept && s_tuser)
        begin
            // Restart the track
            phase_next  = PH_DELTA;
            tick_next   = '0;
            delta_next  = '0;
            status_next = '0;
            chan_next   = '0;
            nrpn_next   = 1'b0;
            meta_next   = '0;
            skip_next   = '0;
            first_next  = '0;
            tempo_next  = '0;
            ended_next  = 1'b0;
        end
        else if (s_accept && !ended_reg)
        begin
            case (phase_reg)
                PH_DELTA:
                begin
                    if (c[7])
                    begin
                        delta_next = delta_sum << 7;
                    end
                    else
                    begin
                        tick_next  = tick_reg + TICK_WIDTH'(delta_sum);
                        delta_next = '0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS, PH_DATA1:
                begin
                    if (phase_reg == PH_STATUS && (c == BYTE_SYSEX || c == BYTE_SYSEX_CONT))
                    begin
                        skip_next  = '0;
                        phase_next = PH_SYSLEN;
                    end
                    else if (phase_reg == PH_STATUS && c == BYTE_META)
                    begin
                        phase_next = PH_METATYPE;
                    end
                    else if (phase_reg == PH_STATUS && c[7])
                    begin
                        chan_next   = c[3:0];
                        status_next = c[6:4];
                        phase_next  = PH_DATA1;
                    end
                    else
                    begin
                        // First data byte
                        first_next = c[6:0];
                        case (status_reg)
                            ST_PROGRAM:
                            begin
                                phase_next = PH_DELTA;
                                ev_valid   = 1'b1;
                                ev.kind    = EV_PROGRAM;
                                ev.key     = c[6:0];
                            end
                            ST_CHANPRESS, ST_SYSTEM:
                            begin
                                phase_next = PH_DELTA;
                            end
                            default:
                            begin
                                phase_next = PH_DATA2;
                            end
                        endcase
                    end
                end
                PH_SYSLEN:
                begin
                    if (c[7])
                    begin
                        skip_next = skip_sum << 7;
                    end
                    else
                    begin
                        skip_next  = skip_sum;
                        phase_next = (skip_sum == '0) ? PH_DELTA : PH_SKIP;
                    end
                end
                PH_METATYPE:
                begin
                    meta_next  = c;
                    skip_next  = '0;
                    phase_next = PH_METALEN;
                end
                PH_METALEN:
                begin
                    if (c[7])
                    begin
                        skip_next = skip_sum << 7;
                    end
                    else
                    begin
                        skip_next = skip_sum;
                        if (meta_reg == META_EOT)
                        begin
                            ended_next = 1'b1;
                            phase_next = PH_DELTA;
                            ev_valid   = 1'b1;
                            ev.kind    = EV_EOT;
                            ev.chan    = '0;
                        end
                        else if (meta_reg == META_TEMPO && skip_sum == 32'(TEMPO_LEN))
                        begin
                            tempo_next = '0;
                            phase_next = PH_TEMPO;
                        end
                        else
                        begin
                            phase_next = (skip_sum == '0) ? PH_DELTA : PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_DELTA;
                    end
                end
                PH_TEMPO:
                begin
                    skip_next = skip_dec;
                    if (skip_dec != '0)
                    begin
                        tempo_next = {tempo_reg[7:0], c};
                    end
                    else
                    begin
                        phase_next = PH_DELTA;
                        ev_valid   = 1'b1;
                        ev.kind    = EV_TEMPO;
                        ev.chan    = '0;
                        ev.tempo   = {tempo_reg, c};
                    end
                end
                PH_DATA2:
                begin
                    phase_next = PH_DELTA;
                    ev.key     = first_reg;
                    case (status_reg)
                        ST_NOTEOFF:
                        begin
                            ev_valid = 1'b1;
                            ev.kind  = EV_NOTEOFF;
                            ev.vel   = c[6:0];
                        end
                        ST_NOTEON:
                        begin
                            ev_valid = 1'b1;
                            ev.kind  = EV_NOTEON;
                            ev.vel   = c[6:0];
                        end
                        ST_KEYPRESS:
                        begin
                            ev_valid = 1'b1;
                            ev.kind  = EV_KEYPRESS;
                            ev.vel   = c[6:0];
                        end
                        ST_PITCHWHEEL:
                        begin
                            ev_valid = 1'b1;
                            ev.kind  = EV_PITCHWHEEL;
                            ev.vel   = c[6:0];
                        end
                        ST_CONTROL:
                        begin
                            // Controller value goes in the key field
                            ev.key = c[6:0];
                            case (first_reg)
                                CC_VOLUME:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_VOLUME;
                                end
                                CC_PAN:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_PAN;
                                end
                                CC_EXPRESSION:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_EXPRESSION;
                                end
                                CC_SUSTAIN:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_SUSTAIN;
                                    ev.key   = {6'd0, c[6]};
                                end
                                CC_SOUNDSOFF:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_SOUNDSOFF;
                                end
                                CC_RESETCTL:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_RESETCTL;
                                end
                                CC_NOTESOFF:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_NOTESOFF;
                                end
                                CC_MONO:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_MONO;
                                end
                                CC_POLY:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_POLY;
                                end
                                CC_BANK:
                                begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_BANK;
                                end
                                CC_RPN_MSB, CC_RPN_LSB, CC_NRPN_MSB, CC_NRPN_LSB:
                                begin
                                    // Select the parameter for this channel
                                    nrpn_next = (first_reg == CC_NRPN_MSB) ||
                                                (first_reg == CC_NRPN_LSB);
                                    wr.en     = 1'b1;
                                    wr.lsb    = (first_reg == CC_RPN_LSB) ||
                                                (first_reg == CC_NRPN_LSB);
                                end
                                CC_DATA_ENTRY:
                                begin
                                    // Look up the selected RPN, decide later
                                    if (!nrpn_reg)
                                    begin
                                        ev_valid  = 1'b1;
                                        ev.kind   = EV_PITCHSENS;
                                        ev.dentry = 1'b1;
                                        rd_en     = 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_DELTA;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            tick_reg   <= '0;
            delta_reg  <= '0;
            status_reg <= '0;
            chan_reg   <= '0;
            nrpn_reg   <= 1'b0;
            meta_reg   <= '0;
            skip_reg   <= '0;
            first_reg  <= '0;
            tempo_reg  <= '0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            delta_reg  <= delta_next;
            status_reg <= status_next;
            chan_reg   <= chan_next;
            nrpn_reg   <= nrpn_next;
            meta_reg   <= meta_next;
            skip_reg   <= skip_next;
            first_reg  <= first_next;
            tempo_reg  <= tempo_next;
            ended_reg  <= ended_next;
        end
    end

    // Per-channel parameter number memory
    mtp_param_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (s_accept && s_tuser),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_chan (chan_reg),
        .rd_word (rd_word)
    );

    // Resolve data entry against the looked-up parameter number
    always_comb
    begin
        fin  = p_reg;
        keep = 1'b1;
        if (p_reg.dentry)
        begin
            if (rd_word == PARAM_PITCHSENS)
            begin
                fin.kind = EV_PITCHSENS;
            end
            else if (rd_word == PARAM_NULL)
            begin
                fin.key = NULL_PITCHSENS;
            end
            else
            begin
                keep = 1'b0;
            end
        end
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                p_valid_reg <= s_accept && ev_valid;
            end
            if (p_move)
            begin
                out_valid_reg <= p_valid_reg && keep;
            end
        end
    end

    // Hold payloads until they move on
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p_reg <= ev;
        end
        if (p_move)
        begin
            out_reg <= fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.tempo, out_reg.vel, out_reg.key, out_reg.chan,
                       out_reg.tick, out_reg.kind};

    `MTP_ASSERT_NEXT(a_restart_clears, s_accept && s_tuser,
        tick_reg == '0 && phase_reg == PH_DELTA && !ended_reg,
        "track restart did not clear parser state")
    `MTP_ASSERT_NEXT(a_ended_frozen, s_accept && !s_tuser && ended_reg,
        $stable(tick_reg) && $stable(phase_reg) && !p_valid_reg,
        "parser moved after end of track")
    `MTP_ASSERT_SAME(a_lookup_phase, rd_en,
        phase_reg == PH_DATA2 && status_reg == ST_CONTROL && !nrpn_reg,
        "parameter lookup outside RPN data entry")
    `MTP_ASSERT_SAME(a_global_chan, out_valid_reg && (out_reg.kind == EV_EOT ||
        out_reg.kind == EV_TEMPO), out_reg.chan == '0 && out_reg.key == '0,
        "tempo or end event carries channel data")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the MIDI track event parser. Directed track fragments
// and random track data are sent as requests. A scoreboard parses each
// accepted byte on its own and checks every event on the master side field
// by field. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import mtp_pkg::*;

    localparam int RANDOM_BYTES = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 8;

    // One decoded event as it should leave the parser
    typedef struct packed {
        kind_t       kind;
        logic [31:0] tick;
        logic [3:0]  chan;
        logic [6:0]  key;
        logic [6:0]  vel;
        logic [23:0] tempo;
    } track_event_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parses the accepted bytes and checks the events
    // ------------------------------------------------------------------------
    class midi_event_scoreboard;
        phase_t       phase;
        logic [31:0]  tick;
        logic [31:0]  delta_sum;
        logic [31:0]  skip_left;
        logic [2:0]   status_class;
        logic [3:0]   chan;
        logic         nrpn_active;
        logic [6:0]   param_msb [16];
        logic [6:0]   param_lsb [16];
        logic [7:0]   meta_kind;
        logic [6:0]   first_value;
        logic [15:0]  tempo_high;
        logic         track_done;
        track_event_t upcoming_events [$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
            restart_track();
        endfunction

        function void restart_track();
            phase        = PH_DELTA;
            tick         = '0;
            delta_sum    = '0;
            skip_left    = '0;
            status_class = ST_NOTEOFF;
            chan         = '0;
            nrpn_active  = 1'b0;
            meta_kind    = '0;
            first_value  = '0;
            tempo_high   = '0;
            track_done   = 1'b0;
            foreach (param_msb[i])
            begin
                param_msb[i] = '0;
                param_lsb[i] = '0;
            end
        endfunction

        function void add_event(kind_t kind, logic [3:0] ch, logic [6:0] key,
                                logic [6:0] vel, logic [23:0] tempo);
            track_event_t ev;
            ev.kind  = kind;
            ev.tick  = tick;
            ev.chan  = ch;
            ev.key   = key;
            ev.vel   = vel;
            ev.tempo = tempo;
            upcoming_events.push_back(ev);
        endfunction

        // Add one byte of a variable-length number; wraps at 32 bits
        function logic [31:0] vlq_add(logic [31:0] sum, logic [7:0] b);
            logic [31:0] total;
            total = sum + 32'(b[6:0]);
            return b[7] ? total << 7 : total;
        endfunction

        // Skip the payload, or go straight to the next delta when empty
        function void end_length();
            if (skip_left == 0)
                phase = PH_DELTA;
            else
                phase = PH_SKIP;
        endfunction

        function void take_first_value(logic [7:0] b);
            first_value = b[6:0];
            case (status_class)
                ST_PROGRAM:
                begin
                    phase = PH_DELTA;
                    add_event(EV_PROGRAM, chan, first_value, '0, '0);
                end
                ST_CHANPRESS, ST_SYSTEM: phase = PH_DELTA;
                default: phase = PH_DATA2;
            endcase
        endfunction

        function void control_change(logic [6:0] value);
            logic [13:0] param;
            param = {param_msb[chan], param_lsb[chan]};
            case (first_value)
                CC_VOLUME:     add_event(EV_VOLUME, chan, value, '0, '0);
                CC_PAN:        add_event(EV_PAN, chan, value, '0, '0);
                CC_EXPRESSION: add_event(EV_EXPRESSION, chan, value, '0, '0);
                CC_SUSTAIN:    add_event(EV_SUSTAIN, chan, {6'd0, value[6]}, '0, '0);
                CC_SOUNDSOFF:  add_event(EV_SOUNDSOFF, chan, value, '0, '0);
                CC_RESETCTL:   add_event(EV_RESETCTL, chan, value, '0, '0);
                CC_NOTESOFF:   add_event(EV_NOTESOFF, chan, value, '0, '0);
                CC_MONO:       add_event(EV_MONO, chan, value, '0, '0);
                CC_POLY:       add_event(EV_POLY, chan, value, '0, '0);
                CC_BANK:       add_event(EV_BANK, chan, value, '0, '0);
                CC_RPN_MSB:
                begin
                    nrpn_active     = 1'b0;
                    param_msb[chan] = value;
                end
                CC_RPN_LSB:
                begin
                    nrpn_active     = 1'b0;
                    param_lsb[chan] = value;
                end
                CC_NRPN_MSB:
                begin
                    nrpn_active     = 1'b1;
                    param_msb[chan] = value;
                end
                CC_NRPN_LSB:
                begin
                    nrpn_active     = 1'b1;
                    param_lsb[chan] = value;
                end
                // data entry reports only pitch sensitivity or the null parameter
                CC_DATA_ENTRY:
                begin
                    if (!nrpn_active && param == PARAM_PITCHSENS)
                        add_event(EV_PITCHSENS, chan, value, '0, '0);
                    else if (!nrpn_active && param == PARAM_NULL)
                        add_event(EV_PITCHSENS, chan, NULL_PITCHSENS, '0, '0);
                end
                default: ;
            endcase
        endfunction

        // Advance the parse by one accepted request
        function void take_byte(logic [7:0] b, logic restart);
            if (restart)
            begin
                restart_track();
                return;
            end
            if (track_done)
                return;
            case (phase)
                PH_DELTA:
                begin
                    delta_sum = vlq_add(delta_sum, b);
                    if (!b[7])
                    begin
                        tick      = tick + delta_sum;
                        delta_sum = '0;
                        phase     = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (b == BYTE_SYSEX || b == BYTE_SYSEX_CONT)
                    begin
                        skip_left = '0;
                        phase     = PH_SYSLEN;
                    end
                    else if (b == BYTE_META)
                        phase = PH_METATYPE;
                    else if (b[7])
                    begin
                        chan         = b[3:0];
                        status_class = b[6:4];
                        phase        = PH_DATA1;
                    end
                    else
                        take_first_value(b);
                end
                PH_SYSLEN:
                begin
                    skip_left = vlq_add(skip_left, b);
                    if (!b[7])
                        end_length();
                end
                PH_METATYPE:
                begin
                    meta_kind = b;
                    skip_left = '0;
                    phase     = PH_METALEN;
                end
                PH_METALEN:
                begin
                    skip_left = vlq_add(skip_left, b);
                    if (!b[7])
                    begin
                        if (meta_kind == META_EOT)
                        begin
                            track_done = 1'b1;
                            phase      = PH_DELTA;
                            add_event(EV_EOT, '0, '0, '0, '0);
                        end
                        else if (meta_kind == META_TEMPO && skip_left == 32'(TEMPO_LEN))
                        begin
                            tempo_high = '0;
                            phase      = PH_TEMPO;
                        end
                        else
                            end_length();
                    end
                end
                PH_SKIP:
                begin
                    skip_left = skip_left - 1;
                    if (skip_left == 0)
                        phase = PH_DELTA;
                end
                PH_TEMPO:
                begin
                    skip_left = skip_left - 1;
                    if (skip_left != 0)
                        tempo_high = {tempo_high[7:0], b};
                    else
                    begin
                        phase = PH_DELTA;
                        add_event(EV_TEMPO, '0, '0, '0, {tempo_high, b});
                    end
                end
                PH_DATA1: take_first_value(b);
                PH_DATA2:
                begin
                    phase = PH_DELTA;
                    case (status_class)
                        ST_NOTEOFF:    add_event(EV_NOTEOFF, chan, first_value, b[6:0], '0);
                        ST_NOTEON:     add_event(EV_NOTEON, chan, first_value, b[6:0], '0);
                        ST_KEYPRESS:   add_event(EV_KEYPRESS, chan, first_value, b[6:0], '0);
                        ST_CONTROL:    control_change(b[6:0]);
                        ST_PITCHWHEEL:
                            add_event(EV_PITCHWHEEL, chan, first_value, b[6:0], '0);
                        default: ;
                    endcase
                end
                default: phase = PH_DELTA;
            endcase
        endfunction

        function void note_mismatch(string what, logic [79:0] want, logic [79:0] got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                note_mismatch(what, {48'd0, want}, {48'd0, got});
        endfunction

        // Compare one accepted event with the oldest one waiting
        function void check_event(logic [79:0] d);
            track_event_t want;
            if (upcoming_events.size() == 0)
            begin
                note_mismatch("event with none waiting", '0, d);
                return;
            end
            want = upcoming_events.pop_front();
            check_field("event_kind", 32'(want.kind), 32'(d[4:0]));
            check_field("tick_time", want.tick, d[36:5]);
            check_field("channel", 32'(want.chan), 32'(d[40:37]));
            check_field("key_or_value", 32'(want.key), 32'(d[47:41]));
            check_field("velocity", 32'(want.vel), 32'(d[54:48]));
            check_field("tempo_us", 32'(want.tempo), 32'(d[78:55]));
            check_field("padding", 32'd0, 32'(d[79]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    midi_event_scoreboard board = new();

    bit         calm        = 1'b0;
    int         sent_count  = 0;
    int         stall_ticks = 0;
    logic [2:0] last_class  = ST_NOTEOFF;

    logic [6:0] cc_numbers [$] = {CC_BANK, CC_DATA_ENTRY, CC_VOLUME, CC_PAN,
                                  CC_EXPRESSION, CC_SUSTAIN, CC_NRPN_LSB, CC_NRPN_MSB,
                                  CC_RPN_LSB, CC_RPN_MSB, CC_SOUNDSOFF, CC_RESETCTL,
                                  CC_NOTESOFF, CC_MONO, CC_POLY};

    // Short track: running status, wrapping delta, null RPN data entry,
    // full-scale tempo, SysEx skip, masked data bits, end of track, then
    // bytes that must be ignored
    logic [7:0] directed_bytes [$] = {8'h00, 8'h90, 8'h00, 8'h7F,
                                      8'h7F, 8'h7F, 8'h00,
                                      8'h90, 8'h80, 8'h80, 8'h80, 8'h05,
                                      8'hBF, 8'h65, 8'h7F,
                                      8'h00, 8'h64, 8'h7F,
                                      8'h00, 8'h06, 8'h40,
                                      8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                                      8'h00, 8'hF0, 8'h01, 8'hAA,
                                      8'h00, 8'hEF, 8'h80, 8'hFF,
                                      8'h00, 8'hFF, 8'h2F, 8'h00,
                                      8'h90, 8'h3C};

    always #2 clk = ~clk;

    midi_track_event_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Stall the event side at random, except during the calm stretch
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 33);

    // Track both handshakes and stop a run that has hung
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_event(m_tdata);
        if (rst_n && s_tvalid && s_tready)
            board.take_byte(s_tdata, s_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_ticks <= 0;
        else
            stall_ticks <= stall_ticks + 1;
        if (stall_ticks >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic [7:0] data_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 8'h00;
        if (r < 10)
            return 8'h7F;
        if (r < 14)
            return 8'($urandom_range(255, 128));
        return 8'($urandom_range(127));
    endfunction

    // Send one request, idling at random first
    task automatic send_byte(input logic [7:0] b, input logic restart = 1'b0,
                             input bit counted = 1'b1);
        while (!calm && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (counted)
            sent_count++;
    endtask

    // Payload length, sometimes with a redundant leading zero group
    task automatic send_length(input int len);
        if ($urandom_range(99) < 15)
            send_byte(8'h80);
        send_byte(8'(len));
    endtask

    // Hold the sender until every event so far has come out
    task automatic wait_for_events();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.upcoming_events.size() != 0)
            @(posedge clk);
    endtask

    // One track event with random content, or now and then a broken one
    task automatic send_random_event();
        int unsigned pick;
        int          n;
        int          i;
        logic [31:0] delta;
        logic [2:0]  cls;
        logic [6:0]  ctl;
        logic [7:0]  b;
        pick = $urandom_range(99);
        // restart the track; its data byte is ignored
        if (pick < 3)
        begin
            send_byte(8'($urandom_range(255)), 1'b1);
            last_class = ST_NOTEOFF;
            return;
        end
        // stray bytes, often followed by a restart
        if (pick < 5)
        begin
            repeat ($urandom_range(3, 1))
                send_byte(8'($urandom_range(255)));
            if ($urandom_range(1) == 1)
            begin
                send_byte(8'h00, 1'b1);
                last_class = ST_NOTEOFF;
            end
            return;
        end

        // delta time, mostly short
        pick = $urandom_range(99);
        if (pick < 45)
            delta = '0;
        else if (pick < 80)
            delta = $urandom_range(127, 1);
        else if (pick < 95)
            delta = $urandom_range(16383, 128);
        else
            delta = $urandom_range(32'h0FFF_FFFF);
        if (pick >= 98)
        begin
            // five groups: the sum can wrap past 32 bits
            repeat (4)
                send_byte({1'b1, 7'($urandom_range(127))});
            send_byte({1'b0, 7'($urandom_range(127))});
        end
        else
        begin
            n = 1;
            while (n < 4 && (delta >> (7 * n)) != 0)
                n++;
            for (i = n - 1; i >= 0; i--)
                send_byte({i != 0, 7'(delta >> (7 * i))});
        end

        pick = $urandom_range(99);
        if (pick < 62)
        begin
            // channel message, new status or running status
            if ($urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                    cls = ST_NOTEON;
                else if (pick < 30)
                    cls = ST_NOTEOFF;
                else if (pick < 38)
                    cls = ST_KEYPRESS;
                else if (pick < 70)
                    cls = ST_CONTROL;
                else if (pick < 80)
                    cls = ST_PROGRAM;
                else if (pick < 88)
                    cls = ST_CHANPRESS;
                else
                    cls = ST_PITCHWHEEL;
                send_byte({1'b1, cls, ($urandom_range(99) < 60) ? 4'($urandom_range(3))
                                                                 : 4'($urandom_range(15))});
                last_class = cls;
            end
            cls = last_class;
            if (cls == ST_CONTROL)
            begin
                if ($urandom_range(99) < 75)
                    ctl = cc_numbers[$urandom_range(cc_numbers.size() - 1)];
                else
                    ctl = 7'($urandom_range(127));
                send_byte({1'b0, ctl});
                // parameter selection favors the pitch-sensitivity and null numbers
                if ((ctl == CC_RPN_MSB || ctl == CC_RPN_LSB || ctl == CC_NRPN_MSB ||
                     ctl == CC_NRPN_LSB) && $urandom_range(1) == 1)
                    send_byte(($urandom_range(1) == 1) ? 8'h7F : 8'h00);
                else
                    send_byte(data_value());
            end
            else
            begin
                send_byte(data_value());
                if (cls != ST_PROGRAM && cls != ST_CHANPRESS && cls != ST_SYSTEM)
                    send_byte(data_value());
            end
        end
        else if (pick < 68)
        begin
            // other system status: one byte follows, no event
            b = 8'($urandom_range(8'hFE, 8'hF1));
            if (b == BYTE_SYSEX_CONT)
                b = 8'hF1;
            send_byte(b);
            send_byte(data_value());
            last_class = ST_SYSTEM;
        end
        else if (pick < 84)
        begin
            send_byte(BYTE_META);
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // tempo, now and then with a wrong length
                send_byte(META_TEMPO);
                n = ($urandom_range(99) < 85) ? int'(TEMPO_LEN) : int'($urandom_range(5));
                send_length(n);
                repeat (n)
                    send_byte(8'($urandom_range(255)));
            end
            else if (pick < 52)
            begin
                // end of track: later bytes are dropped until a restart
                send_byte(META_EOT);
                send_length($urandom_range(2));
                repeat ($urandom_range(3))
                    send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
                last_class = ST_NOTEOFF;
            end
            else
            begin
                // text and other metas: payload skipped
                b = ($urandom_range(1) == 1) ? 8'($urandom_range(15, 1))
                                             : 8'($urandom_range(255));
                if (b == META_EOT || b == META_TEMPO)
                    b = 8'h01;
                send_byte(b);
                n = $urandom_range(4);
                send_length(n);
                repeat (n)
                    send_byte(8'($urandom_range(255)));
            end
        end
        else
        begin
            // SysEx: payload skipped
            send_byte(($urandom_range(1) == 1) ? BYTE_SYSEX : BYTE_SYSEX_CONT);
            n = $urandom_range(5);
            send_length(n);
            repeat (n)
                send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed track, opened and closed by a restart
        send_byte(8'hFF, 1'b1);
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        send_byte(8'h00, 1'b1);
        wait_for_events();

        // random track data with a stretch of no stalls in the middle
        sent_count = 0;
        while (sent_count < RANDOM_BYTES)
        begin
            calm = (sent_count >= 400 && sent_count < 600);
            send_random_event();
        end
        calm = 1'b0;

        wait_for_events();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
